@@ sv/virtual_key_event_queue_assert.svh @@
// assertion macros used by the key event queue top level
`ifndef VIRTUAL_KEY_EVENT_QUEUE_ASSERT_SVH
`define VIRTUAL_KEY_EVENT_QUEUE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define VKQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("key event queue check failed");

// next-cycle implication, checked out of reset
`define VKQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("key event queue check failed");

`endif

@@ sv/vkq_pkg.sv @@
// shared constants, opcodes and control types of the key event queue
package vkq_pkg;

  localparam int NUM_KEYS    = 11;
  localparam int QUEUE_DEPTH = 32;
  localparam int TIMER_BITS  = 16;

  localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int LVL_W     = PTR_W + 1;

  localparam logic [2:0] OP_PRESS       = 3'd0;
  localparam logic [2:0] OP_RELEASE     = 3'd1;
  localparam logic [2:0] OP_TAP         = 3'd2;
  localparam logic [2:0] OP_TICK        = 3'd3;
  localparam logic [2:0] OP_POP         = 3'd4;
  localparam logic [2:0] OP_RELEASE_ALL = 3'd5;

  localparam logic [2:0]  REG_DEFAULT_HOLD  = 3'd0;
  localparam logic [15:0] DEFAULT_HOLD_INIT = 16'd100;

  typedef struct packed {
    logic                 load;
    logic                 key_op;
    logic                 tick_key;
    logic [KEY_IDX_W-1:0] tick_idx;
    logic                 pop_read;
    logic                 clear_all;
    logic                 publish;
  } vkq_cmd_t;

  typedef struct packed {
    logic [2:0] op;
  } vkq_status_t;

endpackage

@@ sv/virtual_key_event_queue.sv @@
// top level of the key edge event queue with per-key tap timers
//
// items come in on start/opcode/key_index/hold_ticks and are taken at an
// edge where start is high and busy is low. each item gives one result on
// the result ports, marked by done for exactly one cycle; the receiver
// cannot stall, so nothing waits on it.
// press, release, tap, pop, release all and unused codes go through
// decode and finish; a tick also runs the key scan between the two,
// which visits one countdown per cycle so that at most one release
// edge enters the ring per cycle. a new item may be taken in the cycle
// that done is high. the event ring is a QUEUE_DEPTH entry memory, one
// write and one registered read per cycle, and holds up to QUEUE_DEPTH-1
// events. default_tap_hold sits at apb byte address 0; the user must
// write it only while the block is idle, which the block does not
// enforce. reset (rst, synchronous) empties the ring, releases all keys,
// disarms the timers and sets the default hold to 100 ticks.
module virtual_key_event_queue import vkq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [4:0]  key_index,
  input  logic [15:0] hold_ticks,
  output logic        done,
  output logic        event_valid,
  output logic [4:0]  event_key,
  output logic        event_edge,
  output logic [10:0] held_mask,
  output logic [4:0]  queue_level,
  output logic        overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "virtual_key_event_queue_assert.svh"

  vkq_cmd_t    cmd;
  vkq_status_t status;
  logic [15:0] default_tap_hold;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_DEFAULT_HOLD) ? {16'd0, default_tap_hold} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_tap_hold <= DEFAULT_HOLD_INIT;
    end else if (psel && penable && pwrite && pready && (paddr == REG_DEFAULT_HOLD)) begin
      default_tap_hold <= pwdata[15:0];
    end
  end

  vkq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  vkq_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .opcode           (opcode),
    .key_index        (key_index),
    .hold_ticks       (hold_ticks),
    .default_tap_hold (default_tap_hold),
    .event_valid      (event_valid),
    .event_key        (event_key),
    .event_edge       (event_edge),
    .held_mask        (held_mask),
    .queue_level      (queue_level),
    .overflow         (overflow)
  );

  // an accepted item keeps the block busy until its result is out
  `VKQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // a result only follows a cycle spent working on an item
  `VKQ_ASSERT_NOW(a_done_after_busy, done, $past(busy))
  // a pop never drops an event
  `VKQ_ASSERT_NOW(a_pop_no_drop, done && event_valid, !overflow)

endmodule

@@ sv/vkq_ctrl.sv @@
// sequencer that walks each item through decode, key scan (ticks only) and result publish
module vkq_ctrl import vkq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  vkq_status_t status,
  output vkq_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TICK,
    S_FINISH
  } state_t;

  state_t               state;
  logic [KEY_IDX_W-1:0] tick_idx;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      tick_idx <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) state <= S_DECODE;
        end
        S_DECODE: begin
          tick_idx <= '0;
          if (status.op == OP_TICK) state <= S_TICK;
          else state <= S_FINISH;
        end
        S_TICK: begin
          if (tick_idx == KEY_IDX_W'(NUM_KEYS - 1)) state <= S_FINISH;
          else tick_idx <= tick_idx + 1'b1;
        end
        S_FINISH: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.tick_idx = tick_idx;
    case (state)
      S_IDLE: cmd.load = start;
      S_DECODE: begin
        cmd.key_op    = (status.op == OP_PRESS) || (status.op == OP_RELEASE) ||
                        (status.op == OP_TAP);
        cmd.pop_read  = (status.op == OP_POP);
        cmd.clear_all = (status.op == OP_RELEASE_ALL);
      end
      S_TICK:   cmd.tick_key = 1'b1;
      S_FINISH: cmd.publish  = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

@@ sv/vkq_datapath.sv @@
// held keys, tap countdowns, event ring and result registers
module vkq_datapath import vkq_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  vkq_cmd_t     cmd,
  output vkq_status_t  status,
  input  logic [2:0]   opcode,
  input  logic [4:0]   key_index,
  input  logic [15:0]  hold_ticks,
  input  logic [15:0]  default_tap_hold,
  output logic         event_valid,
  output logic [4:0]   event_key,
  output logic         event_edge,
  output logic [10:0]  held_mask,
  output logic [4:0]   queue_level,
  output logic         overflow
);

  localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

  logic [2:0]  op_q;
  logic [4:0]  key_q;
  logic [15:0] hold_q;

  logic [NUM_KEYS-1:0]   held;
  logic [TIMER_BITS-1:0] cd [NUM_KEYS];
  logic [5:0]            ring [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr;
  logic [PTR_W-1:0]      rd;
  logic [5:0]            ev_data;
  logic                  ev_valid;
  logic                  dropped;

  logic [KEY_IDX_W-1:0]  sel_idx;
  logic                  key_ok;
  logic                  down;
  logic [TIMER_BITS-1:0] cd_sel;
  logic                  held_sel;
  logic [15:0]           hold_raw;
  logic [TIMER_BITS-1:0] hold_eff;
  logic [PTR_W-1:0]      wr_nxt;
  logic [PTR_W-1:0]      rd_nxt;
  logic                  full;
  logic                  push;
  logic                  push_edge;
  logic [4:0]            push_key;
  logic [LVL_W-1:0]      level;

  assign status.op = op_q;

  assign sel_idx  = cmd.tick_key ? cmd.tick_idx : key_q[KEY_IDX_W-1:0];
  assign key_ok   = {1'b0, key_q} < 6'(NUM_KEYS);
  assign down     = (op_q != OP_RELEASE);
  assign cd_sel   = cd[sel_idx];
  assign held_sel = held[sel_idx];
  assign push_key = cmd.tick_key ? 5'(cmd.tick_idx) : key_q;

  // zero picks the register, a zero register means one tick
  always_comb begin
    hold_raw = (hold_q == 16'd0) ? default_tap_hold : hold_q;
    if (hold_raw == 16'd0) hold_raw = 16'd1;
    if ({17'd0, hold_raw} > TIMER_MAX) hold_eff = TIMER_BITS'(TIMER_MAX);
    else hold_eff = TIMER_BITS'(hold_raw);
  end

  assign wr_nxt = (wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr + 1'b1;
  assign rd_nxt = (rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd + 1'b1;
  assign full   = (wr_nxt == rd);

  // an edge is queued only when the held state really changes
  always_comb begin
    push      = 1'b0;
    push_edge = 1'b0;
    if (cmd.key_op && key_ok) begin
      if (down && !held_sel) begin
        push = 1'b1;
      end else if (!down && held_sel) begin
        push      = 1'b1;
        push_edge = 1'b1;
      end
    end
    if (cmd.tick_key && (cd_sel == TIMER_BITS'(1)) && held_sel) begin
      push      = 1'b1;
      push_edge = 1'b1;
    end
  end

  assign level = (wr >= rd) ? ({1'b0, wr} - {1'b0, rd})
                            : ({1'b0, wr} + LVL_W'(QUEUE_DEPTH) - {1'b0, rd});

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      wr       <= '0;
      rd       <= '0;
      ev_valid <= 1'b0;
      dropped  <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) cd[i] <= '0;
    end else begin
      if (cmd.load) begin
        ev_valid <= 1'b0;
        dropped  <= 1'b0;
      end
      if (cmd.key_op && key_ok) begin
        held[sel_idx] <= down;
        cd[sel_idx]   <= (op_q == OP_TAP) ? hold_eff : '0;
      end
      if (cmd.tick_key && (cd_sel != '0)) begin
        cd[sel_idx] <= cd_sel - 1'b1;
        if (cd_sel == TIMER_BITS'(1)) held[sel_idx] <= 1'b0;
      end
      if (push) begin
        if (full) dropped <= 1'b1;
        else wr <= wr_nxt;
      end
      if (cmd.pop_read) begin
        ev_valid <= (rd != wr);
        if (rd != wr) rd <= rd_nxt;
      end
      if (cmd.clear_all) begin
        held <= '0;
        rd   <= wr;
        for (int i = 0; i < NUM_KEYS; i++) cd[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      key_q  <= key_index;
      hold_q <= hold_ticks;
    end
    if (push && !full) ring[wr] <= {push_edge, push_key};
    if (cmd.pop_read) ev_data <= ring[rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      event_valid <= ev_valid;
      event_key   <= ev_valid ? ev_data[4:0] : 5'd0;
      event_edge  <= ev_valid ? ev_data[5] : 1'b0;
      held_mask   <= 11'(held);
      queue_level <= 5'(level);
      overflow    <= dropped;
    end
  end

endmodule
